// File: rtl/rpsb_pkg.sv
// ----------------------------------------------------------------------------
// rpsb_pkg
// Shared types, codes and helpers for the relay pulse and status blinker.
// ----------------------------------------------------------------------------
package rpsb_pkg;

  localparam int PULSE_BITS = 16;
  localparam int PULSE_IN_W = 16;
  localparam int PERIOD_W   = 10;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int FLASH_W    = 3;

  localparam logic [31:0] PULSE_MAX = 32'((64'd1 << PULSE_BITS) - 64'd1);

  localparam logic [FLASH_W-1:0] RX_TOGGLES = FLASH_W'(2);
  localparam logic [FLASH_W-1:0] TX_TOGGLES = FLASH_W'(4);

  localparam logic [PERIOD_W-1:0] READY_ON_RST  = PERIOD_W'(100);
  localparam logic [PERIOD_W-1:0] READY_OFF_RST = PERIOD_W'(900);
  localparam logic [PERIOD_W-1:0] FLASH_RST     = PERIOD_W'(100);
  localparam logic [PERIOD_W-1:0] ERROR_RST     = PERIOD_W'(200);

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_PULSE   = 2'd1,
    REQ_PATTERN = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    PAT_READY = 3'd0,
    PAT_RX    = 3'd1,
    PAT_TX    = 3'd2,
    PAT_ERROR = 3'd3,
    PAT_OFF   = 3'd4
  } pat_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_READY_ON  = CFG_ADDR_W'(0),
    REG_READY_OFF = CFG_ADDR_W'(1),
    REG_FLASH     = CFG_ADDR_W'(2),
    REG_ERROR     = CFG_ADDR_W'(3)
  } reg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] ready_on;
    logic [PERIOD_W-1:0] ready_off;
    logic [PERIOD_W-1:0] flash_half;
    logic [PERIOD_W-1:0] error_half;
  } periods_t;

  typedef struct packed {
    logic tick;
    logic set;
    pat_t code;
  } led_cmd_t;

  // codes above off fall back to off
  function automatic pat_t to_pattern(logic [2:0] code);
    pat_t p;
    case (code)
      3'(PAT_READY): p = PAT_READY;
      3'(PAT_RX):    p = PAT_RX;
      3'(PAT_TX):    p = PAT_TX;
      3'(PAT_ERROR): p = PAT_ERROR;
      default:       p = PAT_OFF;
    endcase
    return p;
  endfunction

  function automatic logic [PULSE_BITS-1:0] sat_pulse(logic [PULSE_IN_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > PULSE_MAX) begin
      w = PULSE_MAX;
    end
    return w[PULSE_BITS-1:0];
  endfunction

endpackage

// File: rtl/rpsb_ifs.sv
// ----------------------------------------------------------------------------
// rpsb channel interfaces
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rpsb_in_if;
  import rpsb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [PULSE_IN_W-1:0] pulse_ms;
  logic [2:0]            pattern_code;

  modport source (output valid, req_type, pulse_ms, pattern_code, input ready);
  modport sink   (input valid, req_type, pulse_ms, pattern_code, output ready);
endinterface

interface rpsb_out_if;
  logic       valid;
  logic       ready;
  logic       relay_drive;
  logic       led_drive;
  logic [2:0] pattern_now;

  modport source (output valid, relay_drive, led_drive, pattern_now, input ready);
  modport sink   (input valid, relay_drive, led_drive, pattern_now, output ready);
endinterface

interface rpsb_cfg_if;
  import rpsb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/rpsb_led.sv
// ----------------------------------------------------------------------------
// rpsb_led
// Status LED pattern engine: tick-driven toggle timer per pattern.
// ----------------------------------------------------------------------------
module rpsb_led (
  input  logic               clk,
  input  logic               rst_n,
  input  rpsb_pkg::led_cmd_t cmd,
  input  rpsb_pkg::periods_t periods,
  output logic               led_on,
  output rpsb_pkg::pat_t     pattern
);
  import rpsb_pkg::*;

  pat_t                pattern_r, pattern_nxt;
  logic                led_r, led_nxt;
  logic [FLASH_W-1:0]  flashes_r, flashes_nxt;
  logic [PERIOD_W-1:0] wait_r, wait_nxt;

  always_comb begin
    pattern_nxt = pattern_r;
    led_nxt     = led_r;
    flashes_nxt = flashes_r;
    wait_nxt    = wait_r;
    if (cmd.set) begin
      pattern_nxt = cmd.code;
      led_nxt     = 1'b0;
      wait_nxt    = '0;
      case (cmd.code)
        PAT_TX:  flashes_nxt = TX_TOGGLES;
        PAT_RX:  flashes_nxt = RX_TOGGLES;
        default: flashes_nxt = '0;
      endcase
    end else if (cmd.tick) begin
      if (wait_r > PERIOD_W'(1)) begin
        wait_nxt = wait_r - PERIOD_W'(1);
      end else begin
        case (pattern_r)
          PAT_READY: begin
            led_nxt  = ~led_r;
            wait_nxt = led_r ? periods.ready_off : periods.ready_on;
          end
          PAT_RX, PAT_TX: begin
            led_nxt     = ~led_r;
            flashes_nxt = (flashes_r != '0) ? flashes_r - FLASH_W'(1) : '0;
            wait_nxt    = periods.flash_half;
            if (flashes_nxt == '0) begin
              pattern_nxt = PAT_READY;
            end
          end
          PAT_ERROR: begin
            led_nxt  = ~led_r;
            wait_nxt = periods.error_half;
          end
          default: begin
            led_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= PAT_READY;
      led_r     <= 1'b0;
      flashes_r <= '0;
      wait_r    <= '0;
    end else begin
      pattern_r <= pattern_nxt;
      led_r     <= led_nxt;
      flashes_r <= flashes_nxt;
      wait_r    <= wait_nxt;
    end
  end

  assign led_on  = led_r;
  assign pattern = pattern_r;

endmodule

// File: rtl/relay_pulse_and_status_blinker.sv
// ----------------------------------------------------------------------------
// relay_pulse_and_status_blinker
// One-shot relay pulse timer and status LED blinker driven by ms ticks.
// ----------------------------------------------------------------------------
// in_ch carries one request per beat: a 1 ms tick, a relay pulse start with
// its length, or a pattern select. Every request beat yields exactly one
// result beat on out_ch with the relay level, LED level and current pattern
// after that request.
// The result is registered: a request accepted at edge N shows its result
// from edge N onward, one request a cycle unless out_ch stalls. The state
// registers double as the result register, so a request is accepted whenever
// the result slot is empty or is being drained in the same cycle.
// When the receiver stalls, the result holds and in_ch.ready drops until it
// is taken; no result is lost or repeated.
// cfg_ch writes the four period registers (index 0..3, low 10 bits kept);
// other indexes are ignored. It is always ready.
// Synchronous reset clears the relay, selects the ready pattern with the LED
// off, and restores the default periods.
// ----------------------------------------------------------------------------
module relay_pulse_and_status_blinker (
  input logic       clk,
  input logic       rst_n,
  rpsb_in_if.sink   in_ch,
  rpsb_out_if.source out_ch,
  rpsb_cfg_if.sink  cfg_ch
);
  import rpsb_pkg::*;

  periods_t              periods_r;
  logic                  relay_r, relay_nxt;
  logic [PULSE_BITS-1:0] left_r, left_nxt;
  logic                  out_valid_r;
  logic                  in_fire;
  req_t                  req;
  led_cmd_t              led_cmd;
  logic                  led_on;
  pat_t                  pattern;

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign req         = req_t'(in_ch.req_type);

  assign led_cmd.tick = in_fire && (req == REQ_TICK);
  assign led_cmd.set  = in_fire && (req == REQ_PATTERN);
  assign led_cmd.code = to_pattern(in_ch.pattern_code);

  always_comb begin
    relay_nxt = relay_r;
    left_nxt  = left_r;
    if (in_fire) begin
      case (req)
        REQ_TICK: begin
          if (relay_r) begin
            if (left_r <= PULSE_BITS'(1)) begin
              relay_nxt = 1'b0;
            end else begin
              left_nxt = left_r - PULSE_BITS'(1);
            end
          end
        end
        REQ_PULSE: begin
          relay_nxt = 1'b1;
          left_nxt  = sat_pulse(in_ch.pulse_ms);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r     <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      relay_r     <= relay_nxt;
      left_r      <= left_nxt;
      out_valid_r <= in_fire | (out_valid_r & ~out_ch.ready);
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periods_r.ready_on   <= READY_ON_RST;
      periods_r.ready_off  <= READY_OFF_RST;
      periods_r.flash_half <= FLASH_RST;
      periods_r.error_half <= ERROR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        REG_READY_ON:  periods_r.ready_on   <= cfg_ch.data[PERIOD_W-1:0];
        REG_READY_OFF: periods_r.ready_off  <= cfg_ch.data[PERIOD_W-1:0];
        REG_FLASH:     periods_r.flash_half <= cfg_ch.data[PERIOD_W-1:0];
        REG_ERROR:     periods_r.error_half <= cfg_ch.data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rpsb_led u_led (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (led_cmd),
    .periods (periods_r),
    .led_on  (led_on),
    .pattern (pattern)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.relay_drive = relay_r;
  assign out_ch.led_drive   = led_on;
  assign out_ch.pattern_now = 3'(pattern);

endmodule

// File: rtl/rpsb_checker.sv
// ----------------------------------------------------------------------------
// rpsb_checker
// Port-level checks for the relay pulse and status blinker.
// ----------------------------------------------------------------------------
module rpsb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_req_type,
  input logic [2:0] in_pattern_code,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_relay_drive,
  input logic       out_led_drive,
  input logic [2:0] out_pattern_now
);
  import rpsb_pkg::*;

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_relay_drive)
      && $stable(out_led_drive) && $stable(out_pattern_now))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a full, stalled result slot blocks new requests
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted over a pending result");

  a_pulse_raises: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == 2'(REQ_PULSE)
      |=> out_valid && out_relay_drive)
    else $error("pulse request did not raise relay");

  a_rx_select: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == 2'(REQ_PATTERN)
      && in_pattern_code == 3'(PAT_RX)
      |=> out_valid && !out_led_drive && out_pattern_now == 3'(PAT_RX))
    else $error("receive pattern select result wrong");

endmodule

bind relay_pulse_and_status_blinker rpsb_checker u_rpsb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_req_type     (in_ch.req_type),
  .in_pattern_code (in_ch.pattern_code),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_relay_drive (out_ch.relay_drive),
  .out_led_drive   (out_ch.led_drive),
  .out_pattern_now (out_ch.pattern_now)
);
